// ===== src/mkpd_pkg.sv =====
// Shared types and constants for the keypad scanner.
// Used by mkpd_debounce, mkpd_col_scan and the top level.
`timescale 1ns / 1ps
`default_nettype none

package mkpd_pkg;

    localparam int NUM_ROWS        = 4;
    localparam int CNT_W           = 10;
    localparam int DEF_NUM_COLUMNS = 4;
    localparam int CFG_IDX_W       = 2;

    localparam logic [CNT_W-1:0] COLUMN_PERIOD_RST = 10'd10;
    localparam logic [CNT_W-1:0] DEBOUNCE_MS_RST   = 10'd100;

    localparam logic [CFG_IDX_W-1:0] REG_COLUMN_PERIOD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_MS   = 2'd1;

    localparam logic [3:0] KEY_TABLE [0:3][0:3] = '{
        '{4'd1,  4'd2, 4'd3,  4'd12},
        '{4'd4,  4'd5, 4'd6,  4'd13},
        '{4'd7,  4'd8, 4'd9,  4'd14},
        '{4'd10, 4'd0, 4'd11, 4'd15}
    };

    typedef struct packed {
        logic       valid;
        logic [1:0] row;
    } key_hit_t;

endpackage

`default_nettype wire

// ===== src/matrix_keypad_scanner_debounce.sv =====
// Keypad scanner with per-row debounce, one tick beat in, one result beat out.
// Depends on mkpd_pkg, mkpd_debounce and mkpd_col_scan.
//
// Usage:
//   Input channel (in_valid/in_ready, row_edges): one beat per millisecond tick,
//   bit i set when row i saw a rising edge during that tick.
//   Output channel (out_valid/out_ready): exactly one result beat per tick with
//   the column drive after the tick and the debounced key, if any.
//   Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data): index 0 sets
//   column_period, index 1 sets debounce_ms; other indexes are ignored.
//   cfg_ready is always high; write only while no tick is in flight.
// Timing:
//   The result beat is registered and appears in the cycle after its input beat.
//   One tick is taken every cycle unless the output stalls; the single result register sets that rate.
//   in_ready is low only while a result is held and out_ready is low, so a
//   stalled receiver holds the result and backs up the input one beat deep.
// Reset:
//   Column 0 is driven, all row countdowns are zero, the registers take
//   column_period = 10 and debounce_ms = 100, and no result is pending.
`timescale 1ns / 1ps
`default_nettype none

module matrix_keypad_scanner_debounce
    import mkpd_pkg::*;
#(
    parameter int NUM_COLUMNS = DEF_NUM_COLUMNS
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [3:0]           row_edges,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic      [3:0]           column_drive,
    output logic                      key_valid,
    output logic      [1:0]           key_row,
    output logic      [1:0]           key_col,
    output logic      [3:0]           key_code,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CNT_W-1:0]     cfg_data
);

    localparam int COL_W = $clog2(NUM_COLUMNS);

    logic [CNT_W-1:0] column_period_reg;
    logic [CNT_W-1:0] debounce_ms_reg;
    logic             out_valid_reg;
    logic [3:0]       column_drive_reg;
    logic             key_valid_reg;
    logic [1:0]       key_row_reg;
    logic [1:0]       key_col_reg;
    logic [3:0]       key_code_reg;

    logic             tick;
    key_hit_t         hit;
    logic [COL_W-1:0] col_now;
    logic [COL_W-1:0] col_next;
    logic [1:0]       col_low;
    logic [3:0]       drive_next;

    assign cfg_ready = 1'b1;
    assign in_ready  = !out_valid_reg || out_ready;
    assign tick      = in_valid && in_ready;

    mkpd_debounce u_debounce (
        .clk         (clk),
        .rst_n       (rst_n),
        .tick        (tick),
        .row_edges   (row_edges),
        .debounce_ms (debounce_ms_reg),
        .hit         (hit)
    );

    mkpd_col_scan #(
        .NUM_COLUMNS (NUM_COLUMNS)
    ) u_col_scan (
        .clk           (clk),
        .rst_n         (rst_n),
        .tick          (tick),
        .column_period (column_period_reg),
        .col_now       (col_now),
        .col_next      (col_next)
    );

    assign col_low = 2'(col_now);

    always_comb
    begin
        for (int i = 0; i < 4; i++)
            drive_next[i] = (32'(col_next) == i);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_period_reg <= COLUMN_PERIOD_RST;
            debounce_ms_reg   <= DEBOUNCE_MS_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == REG_COLUMN_PERIOD)
                column_period_reg <= cfg_data;
            else if (cfg_index == REG_DEBOUNCE_MS)
                debounce_ms_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_ready)
            out_valid_reg <= in_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_drive_reg <= 4'b0001;
            key_valid_reg    <= 1'b0;
            key_row_reg      <= 2'd0;
            key_col_reg      <= 2'd0;
            key_code_reg     <= 4'd0;
        end
        else if (tick)
        begin
            column_drive_reg <= drive_next;
            key_valid_reg    <= hit.valid;
            key_row_reg      <= hit.valid ? hit.row : 2'd0;
            key_col_reg      <= hit.valid ? col_low : 2'd0;
            key_code_reg     <= hit.valid ? KEY_TABLE[hit.row][col_low] : 4'd0;
        end
    end

    assign out_valid    = out_valid_reg;
    assign column_drive = column_drive_reg;
    assign key_valid    = key_valid_reg;
    assign key_row      = key_row_reg;
    assign key_col      = key_col_reg;
    assign key_code     = key_code_reg;

endmodule

`default_nettype wire

// ===== src/mkpd_debounce.sv =====
// Per-row quiet countdowns and highest-row key selection.
// Depends on mkpd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mkpd_debounce
    import mkpd_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                tick,
    input  wire logic [NUM_ROWS-1:0] row_edges,
    input  wire logic [CNT_W-1:0]    debounce_ms,
    output key_hit_t                 hit
);

    logic [CNT_W-1:0] quiet_reg  [NUM_ROWS];
    logic [CNT_W-1:0] quiet_next [NUM_ROWS];

    always_comb
    begin
        logic [CNT_W-1:0] dec;
        hit = '0;
        for (int r = 0; r < NUM_ROWS; r++)
        begin
            dec = (quiet_reg[r] == '0) ? '0 : quiet_reg[r] - 1'b1;
            quiet_next[r] = dec;
            if (row_edges[r])
            begin
                if (dec == '0)
                begin
                    hit.valid = 1'b1;
                    hit.row   = 2'(r);
                end
                quiet_next[r] = debounce_ms;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < NUM_ROWS; r++)
                quiet_reg[r] <= '0;
        end
        else if (tick)
        begin
            for (int r = 0; r < NUM_ROWS; r++)
                quiet_reg[r] <= quiet_next[r];
        end
    end

endmodule

`default_nettype wire

// ===== src/mkpd_col_scan.sv =====
// Column scan counter: holds the active column and its tick count.
// Depends on mkpd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mkpd_col_scan
    import mkpd_pkg::*;
#(
    parameter int NUM_COLUMNS = DEF_NUM_COLUMNS,
    localparam int COL_W      = $clog2(NUM_COLUMNS)
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             tick,
    input  wire logic [CNT_W-1:0] column_period,
    output logic      [COL_W-1:0] col_now,
    output logic      [COL_W-1:0] col_next
);

    localparam logic [COL_W-1:0] LAST_COL = COL_W'(NUM_COLUMNS - 1);

    logic [COL_W-1:0] col_reg;
    logic [CNT_W-1:0] ticks_reg;
    logic [CNT_W-1:0] ticks_next;
    logic [CNT_W-1:0] ticks_inc;
    logic [CNT_W-1:0] period;

    assign col_now   = col_reg;
    assign ticks_inc = ticks_reg + 1'b1;
    assign period    = (column_period == '0) ? CNT_W'(1) : column_period;

    always_comb
    begin
        ticks_next = ticks_inc;
        col_next   = col_reg;
        if (ticks_inc >= period)
        begin
            ticks_next = '0;
            col_next   = (col_reg == LAST_COL) ? '0 : col_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= '0;
            ticks_reg <= '0;
        end
        else if (tick)
        begin
            col_reg   <= col_next;
            ticks_reg <= ticks_next;
        end
    end

endmodule

`default_nettype wire
